// ===== rtl/core/gee_pkg.sv =====
// ----------------------------------------------------------------------------
// gee_pkg
// shared constants and types of the gf(2) extended euclid core
// ----------------------------------------------------------------------------
package gee_pkg;

  // polynomial word width inside the core (2..64)
  localparam int POLY_WIDTH = 64;
  // bits of a degree index
  localparam int DEG_W = (POLY_WIDTH > 2) ? $clog2(POLY_WIDTH) : 1;
  // width of each field on the ports
  localparam int FIELD_W = 64;

  typedef logic [POLY_WIDTH-1:0] poly_t;
  typedef logic [DEG_W-1:0]      deg_t;

  // working set of the remainder sequence
  typedef struct packed {
    poly_t r;
    poly_t rr;
    poly_t u;
    poly_t uu;
    poly_t v;
    poly_t vv;
  } gee_regs_t;

  // reduced values after one shift-and-xor step
  typedef struct packed {
    poly_t r;
    poly_t u;
    poly_t v;
  } gee_red_t;

endpackage

// ===== rtl/core/gf2_extended_euclid_core.sv =====
// ----------------------------------------------------------------------------
// gf2_extended_euclid_core
// extended euclid over gf(2) polynomials: gcd and bezout multipliers
// ----------------------------------------------------------------------------
//
// channel   dir  tdata fields (lowest bit up)             bits
// s_axis    in   poly_a[63:0], poly_b[127:64]              128
// m_axis    out  gcd_poly[63:0], coef_u[127:64],           192
//                coef_v[191:128]
//
// steps: after the accept, each cycle the sequencer either lowers one degree
//   counter by one, applies one quotient term through the shared shifter,
//   or swaps roles, until rr is zero
// reset: rst is synchronous, active high, clears the sequencer and m_tvalid
// stalls: s_tready is high only while no request is in work; a finished
//   result sits in the output register, and the next request is taken
//   while it waits; a result that cannot leave holds the sequencer
//
module gf2_extended_euclid_core (
  input  logic         clk,
  input  logic         rst,
  // poly_a [63:0], poly_b [127:64]
  input  logic [127:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // gcd_poly [63:0], coef_u [127:64], coef_v [191:128]
  output logic [191:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready
);

  localparam int W  = gee_pkg::POLY_WIDTH;
  localparam int FW = gee_pkg::FIELD_W;

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // step kinds, picked each cycle while running
  localparam logic [2:0] STEP_DONE    = 3'd0;
  localparam logic [2:0] STEP_NORM_RR = 3'd1;
  localparam logic [2:0] STEP_NORM_R  = 3'd2;
  localparam logic [2:0] STEP_SWAP    = 3'd3;
  localparam logic [2:0] STEP_REDUCE  = 3'd4;

  logic                 state, state_next;
  gee_pkg::gee_regs_t   regs, regs_next;
  gee_pkg::deg_t        deg_r, deg_r_next;
  gee_pkg::deg_t        deg_rr, deg_rr_next;
  logic [2:0]           step;
  gee_pkg::gee_red_t    red;
  gee_pkg::deg_t        shamt;
  logic                 r_top, rr_top, rr_zero;
  logic                 out_load;
  logic                 s_fire;

  function automatic gee_pkg::poly_t poly_t_one();
    gee_pkg::poly_t one;
    one    = '0;
    one[0] = 1'b1;
    return one;
  endfunction

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // degree counters are upper bounds; the bit under each is checked
  assign r_top   = regs.r[deg_r];
  assign rr_top  = regs.rr[deg_rr];
  assign rr_zero = (regs.rr == '0);
  assign shamt   = deg_r - deg_rr;

  gee_shift_unit u_shift (
    .cur   (regs),
    .shamt (shamt),
    .red   (red)
  );

  // step choice: divisor gone ends the run, then tighten degrees,
  // then either reduce r by a shifted rr or hand the remainder over
  always_comb begin
    priority if (rr_zero) begin
      step = STEP_DONE;
    end else if (!rr_top) begin
      step = STEP_NORM_RR;
    end else if (!r_top && (deg_r != '0)) begin
      step = STEP_NORM_R;
    end else if (!r_top) begin
      // r has become zero
      step = STEP_SWAP;
    end else if (deg_r >= deg_rr) begin
      step = STEP_REDUCE;
    end else begin
      step = STEP_SWAP;
    end
  end

  assign out_load = (state == ST_RUN) && (step == STEP_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    regs_next   = regs;
    deg_r_next  = deg_r;
    deg_rr_next = deg_rr;
    state_next  = state;
    if (state == ST_IDLE) begin
      if (s_fire) begin
        regs_next.r  = s_tdata[W-1:0];
        regs_next.rr = s_tdata[FW +: W];
        regs_next.u  = poly_t_one();
        regs_next.uu = '0;
        regs_next.v  = '0;
        regs_next.vv = poly_t_one();
        deg_r_next   = gee_pkg::deg_t'(W - 1);
        deg_rr_next  = gee_pkg::deg_t'(W - 1);
        state_next   = ST_RUN;
      end
    end else begin
      unique case (step)
        STEP_DONE: begin
          if (out_load) begin
            state_next = ST_IDLE;
          end
        end
        STEP_NORM_RR: begin
          deg_rr_next = deg_rr - 1'b1;
        end
        STEP_NORM_R: begin
          deg_r_next = deg_r - 1'b1;
        end
        STEP_SWAP: begin
          regs_next.r  = regs.rr;
          regs_next.rr = regs.r;
          regs_next.u  = regs.uu;
          regs_next.uu = regs.u;
          regs_next.v  = regs.vv;
          regs_next.vv = regs.v;
          deg_r_next   = deg_rr;
          deg_rr_next  = deg_r;
        end
        STEP_REDUCE: begin
          regs_next.r = red.r;
          regs_next.u = red.u;
          regs_next.v = red.v;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working set and result register, no reset needed
  always_ff @(posedge clk) begin
    regs   <= regs_next;
    deg_r  <= deg_r_next;
    deg_rr <= deg_rr_next;
    if (out_load) begin
      m_tdata[0 +: FW]      <= FW'(regs.r);
      m_tdata[FW +: FW]     <= FW'(regs.u);
      m_tdata[2*FW +: FW]   <= FW'(regs.v);
    end
  end

  // a taken request always starts a run
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state == ST_RUN))
    else $error("request taken but sequencer not running");

  // no bit of rr above its degree counter while running
  a_rr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (((regs.rr >> deg_rr) >> 1) == '0))
    else $error("rr has bits above its degree counter");

  // no bit of r above its degree counter while running
  a_r_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (((regs.r >> deg_r) >> 1) == '0))
    else $error("r has bits above its degree counter");

  // a result is written only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrote a waiting result");

endmodule

// ===== rtl/core/gee_shift_unit.sv =====
// ----------------------------------------------------------------------------
// gee_shift_unit
// shared shift-and-xor unit: one long-division term applied to r, u and v
// ----------------------------------------------------------------------------
module gee_shift_unit (
  input  gee_pkg::gee_regs_t cur,
  input  gee_pkg::deg_t      shamt,
  output gee_pkg::gee_red_t  red
);

  // one quotient term X^shamt: subtract shifted divisor, fold the term
  // into the bezout multipliers; bits past the word drop out
  always_comb begin
    red.r = cur.r ^ (cur.rr << shamt);
    red.u = cur.u ^ (cur.uu << shamt);
    red.v = cur.v ^ (cur.vv << shamt);
  end

endmodule

// ===== tb/gf2_extended_euclid_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_extended_euclid_core_tb
// self-checking bench for the gf(2) extended euclid core: every request is
// predicted in the bench (gcd plus bezout multipliers) and each result is
// compared in order, under random idling on both stream sides, a long output
// stall and a full drain between phases
// ----------------------------------------------------------------------------
module gf2_extended_euclid_core_tb;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 10;
  // no handshake for this long means the core is stuck
  localparam int          WATCHDOG_LIMIT = 5000;
  // margin after the final drain for a stray result to show up
  localparam int          DRAIN_CYCLES   = 5 * gee_pkg::POLY_WIDTH + 20;
  // long enough for one result to wait and a second to hold the sequencer
  localparam int          HOLD_CYCLES    = 1000;
  localparam int          PHASE_ITEMS    = 300;
  localparam logic [63:0] WORD_MASK      =
    (gee_pkg::POLY_WIDTH >= 64) ? '1 : ((64'd1 << gee_pkg::POLY_WIDTH) - 64'd1);

  typedef struct packed {
    logic [63:0] gcd_poly;
    logic [63:0] coef_u;
    logic [63:0] coef_v;
  } euclid_result_t;

  logic         clk;
  logic         rst;
  // poly_a [63:0], poly_b [127:64]
  logic [127:0] s_tdata;
  logic         s_tvalid;
  logic         s_tready;
  // gcd_poly [63:0], coef_u [127:64], coef_v [191:128]
  logic [191:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready;

  euclid_result_t gcd_expected_q[$];
  int             err_count     = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             recv_hold_len = 0;
  int             quiet_cycles  = 0;

  gf2_extended_euclid_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: remainder sequence with long division and carry-less products
  // ---------------------------------------------------------------------------

  // index of the top set coefficient, -1 for the zero polynomial
  function automatic int poly_deg(logic [63:0] p);
    int d;
    d = -1;
    for (int i = 0; i < 64; i++)
      if (p[i]) d = i;
    return d;
  endfunction

  // carry-less product, truncated to the word
  function automatic logic [63:0] clmul(logic [63:0] x, logic [63:0] y);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i++)
      if (y[i]) acc ^= x << i;
    return acc & WORD_MASK;
  endfunction

  function automatic euclid_result_t euclid_predict(logic [63:0] a, logic [63:0] b);
    logic [63:0]    r, rr, u, uu, v, vv;
    logic [63:0]    quo, rem, nu, nv;
    int             dd, dr;
    euclid_result_t res;
    r  = a & WORD_MASK;
    rr = b & WORD_MASK;
    u  = 64'd1;
    uu = 64'd0;
    v  = 64'd0;
    vv = 64'd1;
    while (rr != 0) begin
      // long division of r by rr
      quo = '0;
      rem = r;
      dd  = poly_deg(rr);
      dr  = poly_deg(rem);
      while (dr >= dd) begin
        quo[dr - dd] = 1'b1;
        rem ^= rr << (dr - dd);
        dr = poly_deg(rem);
      end
      nu = u ^ clmul(quo, uu);
      nv = v ^ clmul(quo, vv);
      r  = rr;
      rr = rem;
      u  = uu;
      uu = nu;
      v  = vv;
      vv = nv;
    end
    res.gcd_poly = r & WORD_MASK;
    res.coef_u   = u & WORD_MASK;
    res.coef_v   = v & WORD_MASK;
    return res;
  endfunction

  // random polynomial of exactly degree deg (zero for deg < 0)
  function automatic logic [63:0] rand_poly(int deg);
    logic [63:0] p;
    p = {$urandom, $urandom};
    if (deg < 0) return '0;
    if (deg < 63) p &= (64'd1 << (deg + 1)) - 64'd1;
    p[deg] = 1'b1;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: inputs change at the falling edge only
  // ---------------------------------------------------------------------------

  // offers one request after random idle cycles, returns at the falling edge
  // after acceptance with s_tvalid still high
  task automatic send_operands(logic [63:0] a, logic [63:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = {$urandom, $urandom, $urandom, $urandom};
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {b, a};
    do @(posedge clk); while (!s_tready);
    gcd_expected_q.push_back(euclid_predict(a, b));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    s_tvalid = 1'b0;
    while (gcd_expected_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_len > 0) begin
        m_tready = 1'b0;
        recv_hold_len--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // compare each result with the oldest pending request, field by field
  always @(posedge clk) begin
    euclid_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (gcd_expected_q.size() == 0) begin
        $error("result with no request pending: gcd_poly %h", m_tdata[63:0]);
        err_count++;
      end else begin
        want = gcd_expected_q.pop_front();
        if (m_tdata[63:0] !== want.gcd_poly) begin
          $error("gcd_poly: expected %h, actual %h", want.gcd_poly, m_tdata[63:0]);
          err_count++;
        end
        if (m_tdata[127:64] !== want.coef_u) begin
          $error("coef_u: expected %h, actual %h", want.coef_u, m_tdata[127:64]);
          err_count++;
        end
        if (m_tdata[191:128] !== want.coef_v) begin
          $error("coef_v: expected %h, actual %h", want.coef_v, m_tdata[191:128]);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles in a row with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gf2_extended_euclid_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero operands, unit operands, equal operands and extreme degrees
  task automatic test_special_cases();
    logic [63:0] p;
    send_operands(64'd0, 64'd0);
    send_operands(64'd0, 64'h1d);
    send_operands(64'h1d, 64'd0);
    send_operands(64'd0, '1);
    send_operands('1, 64'd0);
    send_operands(64'd1, 64'd1);
    send_operands(64'd1, '1);
    send_operands('1, 64'd1);
    send_operands('1, '1);
    send_operands(64'h8000_0000_0000_0000, 64'd1);
    send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
    send_operands(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_operands(64'd3, 64'd2);
    send_operands(64'd2, 64'd3);
    // x^64 would be out of range, so degree 63 against degree 62
    send_operands(rand_poly(63), rand_poly(62));
    p = rand_poly(40);
    send_operands(p, p);
    // common factor of degree 32
    p = rand_poly(32);
    send_operands(clmul(p, rand_poly(31)), clmul(p, rand_poly(20)));
    // degree 63 against degree 63, then a constant against degree 63
    send_operands(rand_poly(63), rand_poly(63));
    send_operands(rand_poly(0), rand_poly(63));
  endtask

  task automatic test_random_pairs(int n_items);
    logic [63:0] a, b, g;
    int          dg;
    for (int n = 0; n < n_items; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
        end
        4, 5: begin
          a = rand_poly($urandom_range(0, 63));
          b = rand_poly($urandom_range(0, 63));
        end
        6, 7: begin
          // shared factor so the gcd is not trivial
          dg = $urandom_range(1, 48);
          g  = rand_poly(dg);
          a  = clmul(g, rand_poly($urandom_range(0, 63 - dg)));
          b  = clmul(g, rand_poly($urandom_range(0, 63 - dg)));
        end
        8: begin
          a = rand_poly($urandom_range(0, 3));
          b = {$urandom, $urandom};
          if ($urandom_range(0, 1)) {a, b} = {b, a};
          if ($urandom_range(0, 3) == 0) b = a;
        end
        default: begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
          if ($urandom_range(0, 1)) a = '0;
          else b = '0;
        end
      endcase
      send_operands(a, b);
    end
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    recv_hold_len = HOLD_CYCLES;
    for (int n = 0; n < 6; n++)
      send_operands({$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = saved_idle;
    wait_results_drained();
  endtask

  // sender waits for every pending result before each short burst
  task automatic test_sender_pause();
    for (int k = 0; k < 4; k++) begin
      wait_results_drained();
      test_random_pairs(5);
    end
    wait_results_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 51;
    test_special_cases();
    test_random_pairs(PHASE_ITEMS);
    test_output_backpressure();

    send_idle_pct = 51;
    recv_idle_pct = 31;
    test_random_pairs(PHASE_ITEMS);
    test_sender_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_pairs(PHASE_ITEMS);

    // let any stray result show up before the verdict
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("gf2_extended_euclid_core test passed");
    else
      $display("gf2_extended_euclid_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gee_pkg.sv
rtl/core/gee_shift_unit.sv
rtl/core/gf2_extended_euclid_core.sv
tb/gf2_extended_euclid_core_tb.sv
